>>> rtl/core/reinforced_template_table_top_defines.svh
// Assertion macros shared by the template table RTL.
`ifndef REINFORCED_TEMPLATE_TABLE_TOP_DEFINES_SVH
`define REINFORCED_TEMPLATE_TABLE_TOP_DEFINES_SVH
// Assert that a property holds on every clock edge outside reset.
`define RTT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert without a reset qualifier.
`define RTT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/core/rtt_pkg.sv
// ----------------------------------------------------------------------------
// rtt_pkg
// Types and constants of the reinforced template table.
// ----------------------------------------------------------------------------
package rtt_pkg;
    localparam int Capacity = 64;
    localparam int SlotW = $clog2(Capacity);
    localparam int CountW = $clog2(Capacity + 1);
    localparam logic [15:0] Sat16 = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_LOCAL  = 2'd0,
        OP_WIRE   = 2'd1,
        OP_REPORT = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ACT_UPDATED  = 3'd0,
        ACT_APPENDED = 3'd1,
        ACT_REPLACED = 3'd2,
        ACT_REJECTED = 3'd3,
        ACT_REPORT   = 3'd4
    } t_action;

    typedef struct packed {
        logic [31:0] hash;
        logic [15:0] reinforce;
        logic [15:0] last_seen;
        logic [15:0] interval_min;
        logic [15:0] interval_max;
    } t_entry;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] key_hash;
        logic [15:0] record_count;
        logic [15:0] interval_min_ms;
        logic [15:0] interval_max_ms;
        logic [15:0] sweep_number;
        logic [6:0]  report_count;
    } t_req;

    typedef struct packed {
        logic [2:0]  action;
        logic        accepted;
        logic [5:0]  slot;
        logic [31:0] row_hash;
        logic [15:0] row_reinforce;
        logic [15:0] row_last_seen;
        logic [15:0] row_interval_min;
        logic [15:0] row_interval_max;
        logic        last;
    } t_rsp;
endpackage

>>> rtl/core/rtt_if.sv
// ----------------------------------------------------------------------------
// rtt_req_if / rtt_rsp_if / rtt_cfg_if
// Valid/ready channels of the template table.
// ----------------------------------------------------------------------------
interface rtt_req_if import rtt_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtt_rsp_if import rtt_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rtt_cfg_if ();
    logic       valid;
    logic       ready;
    logic [6:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/core/reinforced_template_table_top.sv
// ----------------------------------------------------------------------------
// reinforced_template_table_top
// Template table with least-frequently-used replacement, held in one RAM.
// ----------------------------------------------------------------------------
//  channel   | dir | word
//  i_req     | in  | operation, key, count, interval range, sweep, report count
//  o_rsp     | out | action, accepted, slot, entry row, last
//  i_cfg     | in  | capacity_in_use
//
// A merge scans the n filled entries through the RAM read port, one per cycle.
// A match ends the scan early. The result word is registered in S_EMIT, held in
// S_WAIT until it leaves, and the machine then takes the next request from idle.
// A report rescans the table for each row.
// Reset empties the table and sets the full capacity; the RAM needs no clearing.
// A stalled result holds the machine; the next request is taken once idle.
module reinforced_template_table_top
    import rtt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    rtt_req_if.sink   i_req,
    rtt_rsp_if.source o_rsp,
    rtt_cfg_if.sink   i_cfg
);
`include "reinforced_template_table_top_defines.svh"

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_RDROW, S_EMIT, S_WAIT
    } t_state;

    t_entry mem [Capacity];
    t_entry r_rdata;

    t_state           r_state;
    t_req             r_req;
    logic [CountW-1:0] r_fill, r_cap;
    logic [CountW-1:0] r_idx;      // address issued
    logic [CountW-1:0] r_cmp;      // index of data in r_rdata
    logic              r_cmp_v;
    logic              r_found;
    logic [SlotW-1:0]  r_best;
    t_entry            r_best_e;
    logic              r_prev_v;
    logic [15:0]       r_prev_cnt;
    logic [15:0]       r_prev_seen;
    logic [SlotW-1:0]  r_prev_slot;
    logic [CountW-1:0] r_rows;
    logic [CountW-1:0] r_take;
    t_rsp              r_rsp;
    logic              r_rsp_v;

    logic [CountW-1:0] cap_eff;
    always_comb begin
        cap_eff = r_cap;
        if (r_cap > CountW'(Capacity)) cap_eff = CountW'(Capacity);
        if (r_cap == '0) cap_eff = CountW'(1);
    end

    // Comparison of the entry read in the last cycle against the best so far.
    logic better;
    always_comb begin
        better = 1'b0;
        if (r_req.operation == OP_REPORT) begin
            better = !r_found ||
                     r_rdata.reinforce > r_best_e.reinforce ||
                     (r_rdata.reinforce == r_best_e.reinforce &&
                      r_rdata.last_seen > r_best_e.last_seen);
        end else begin
            better = !r_found ||
                     r_rdata.reinforce < r_best_e.reinforce ||
                     (r_rdata.reinforce == r_best_e.reinforce &&
                      r_rdata.last_seen < r_best_e.last_seen);
        end
    end

    // Report rows come out in rank order, so an entry is still a candidate
    // only when it ranks below the row emitted last.
    logic eligible;
    assign eligible = (r_req.operation != OP_REPORT) || !r_prev_v ||
                      r_rdata.reinforce < r_prev_cnt ||
                      (r_rdata.reinforce == r_prev_cnt &&
                       (r_rdata.last_seen < r_prev_seen ||
                        (r_rdata.last_seen == r_prev_seen &&
                         r_cmp[SlotW-1:0] > r_prev_slot)));

    logic hit;
    assign hit = r_cmp_v && (r_req.operation != OP_REPORT) &&
                 (r_rdata.hash == r_req.key_hash);

    // Merged version of the matching entry.
    t_entry merged;
    logic   changed;
    always_comb begin
        merged = r_rdata;
        changed = 1'b0;
        if (r_req.operation == OP_LOCAL) begin
            if (r_rdata.reinforce < Sat16) merged.reinforce = r_rdata.reinforce + 16'd1;
            changed = 1'b1;
        end else if (r_req.record_count > r_rdata.reinforce) begin
            merged.reinforce = r_req.record_count;
            changed = 1'b1;
        end
        merged.last_seen = r_req.sweep_number;
        if (r_req.interval_min_ms < r_rdata.interval_min) begin
            merged.interval_min = r_req.interval_min_ms;
            changed = 1'b1;
        end
        if (r_req.interval_max_ms > r_rdata.interval_max) begin
            merged.interval_max = r_req.interval_max_ms;
            changed = 1'b1;
        end
    end

    t_entry fresh;
    assign fresh = '{hash: r_req.key_hash, reinforce: r_req.record_count,
                     last_seen: r_req.sweep_number,
                     interval_min: r_req.interval_min_ms,
                     interval_max: r_req.interval_max_ms};

    logic   we;
    logic [SlotW-1:0] waddr;
    t_entry wdata;

    logic rd_en;
    assign rd_en = (r_state == S_SCAN) && (r_idx < r_fill);

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        if (rd_en) r_rdata <= mem[r_idx[SlotW-1:0]];
    end

    assign i_req.ready = (r_state == S_IDLE) && !r_rsp_v;
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = r_rsp_v;
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        we <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_cap   <= CountW'(Capacity);
            r_rsp_v <= 1'b0;
            r_cmp_v <= 1'b0;
            r_rows  <= '0;
            r_take  <= '0;
        end else begin
            if (i_cfg.valid) r_cap <= i_cfg.data;
            if (r_rsp_v && o_rsp.ready) r_rsp_v <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req    <= i_req.data;
                        r_idx    <= '0;
                        r_found  <= 1'b0;
                        r_cmp_v  <= 1'b0;
                        r_prev_v <= 1'b0;
                        r_rows   <= '0;
                        r_take   <= (i_req.data.report_count < r_fill) ?
                                    CountW'(i_req.data.report_count) : r_fill;
                        if (i_req.data.operation == OP_NONE) begin
                            r_state <= S_IDLE;
                        end else if (i_req.data.operation == OP_REPORT &&
                                     (i_req.data.report_count == '0 || r_fill == '0)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // Pipeline: read entry r_idx, compare entry r_cmp.
                    if (r_idx < r_fill) begin
                        r_idx   <= r_idx + 1'b1;
                    end
                    r_cmp   <= r_idx;
                    r_cmp_v <= r_idx < r_fill;
                    if (hit) begin
                        we    <= 1'b1;
                        waddr <= r_cmp[SlotW-1:0];
                        wdata <= merged;
                        r_rsp <= '{action: ACT_UPDATED,
                                   accepted: (r_req.operation == OP_LOCAL) || changed,
                                   slot: r_cmp[SlotW-1:0], row_hash: merged.hash,
                                   row_reinforce: merged.reinforce,
                                   row_last_seen: merged.last_seen,
                                   row_interval_min: merged.interval_min,
                                   row_interval_max: merged.interval_max, last: 1'b1};
                        r_state <= S_EMIT;
                    end else begin
                        if (r_cmp_v && eligible && better) begin
                            r_best   <= r_cmp[SlotW-1:0];
                            r_best_e <= r_rdata;
                            r_found  <= 1'b1;
                        end
                        if (!(r_idx < r_fill) && !r_cmp_v) r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_cmp_v <= 1'b0;
                    if (r_req.operation == OP_REPORT) begin
                        r_prev_v    <= 1'b1;
                        r_prev_cnt  <= r_best_e.reinforce;
                        r_prev_seen <= r_best_e.last_seen;
                        r_prev_slot <= r_best;
                        r_rows <= r_rows + 1'b1;
                        r_rsp <= '{action: ACT_REPORT, accepted: 1'b0, slot: r_best,
                                   row_hash: r_best_e.hash,
                                   row_reinforce: r_best_e.reinforce,
                                   row_last_seen: r_best_e.last_seen,
                                   row_interval_min: r_best_e.interval_min,
                                   row_interval_max: r_best_e.interval_max,
                                   last: (r_rows + 1'b1) == r_take};
                        r_state <= S_EMIT;
                    end else if (r_fill < cap_eff) begin
                        we    <= 1'b1;
                        waddr <= r_fill[SlotW-1:0];
                        wdata <= fresh;
                        r_fill <= r_fill + 1'b1;
                        r_rsp <= '{action: ACT_APPENDED, accepted: 1'b1,
                                   slot: r_fill[SlotW-1:0], row_hash: fresh.hash,
                                   row_reinforce: fresh.reinforce,
                                   row_last_seen: fresh.last_seen,
                                   row_interval_min: fresh.interval_min,
                                   row_interval_max: fresh.interval_max, last: 1'b1};
                        r_state <= S_EMIT;
                    end else if (r_req.record_count < r_best_e.reinforce) begin
                        r_rsp <= '{action: ACT_REJECTED, accepted: 1'b0, slot: r_best,
                                   row_hash: r_best_e.hash,
                                   row_reinforce: r_best_e.reinforce,
                                   row_last_seen: r_best_e.last_seen,
                                   row_interval_min: r_best_e.interval_min,
                                   row_interval_max: r_best_e.interval_max, last: 1'b1};
                        r_state <= S_EMIT;
                    end else begin
                        we    <= 1'b1;
                        waddr <= r_best;
                        wdata <= fresh;
                        r_rsp <= '{action: ACT_REPLACED, accepted: 1'b1, slot: r_best,
                                   row_hash: fresh.hash,
                                   row_reinforce: fresh.reinforce,
                                   row_last_seen: fresh.last_seen,
                                   row_interval_min: fresh.interval_min,
                                   row_interval_max: fresh.interval_max, last: 1'b1};
                        r_state <= S_EMIT;
                    end
                end
                S_RDROW: begin
                    r_state <= S_SCAN;
                end
                S_EMIT: begin
                    r_rsp_v <= 1'b1;
                    r_cmp_v <= 1'b0;
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (o_rsp.ready) begin
                        if (r_req.operation == OP_REPORT && !r_rsp.last) begin
                            r_idx   <= '0;
                            r_found <= 1'b0;
                            r_state <= S_RDROW;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `RTT_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= CountW'(Capacity), "fill above capacity")
    `RTT_ASSERT(a_idle_no_rsp, i_clk, i_rst_n, i_req.ready |-> !r_rsp_v, "word pending")
    `RTT_ASSERT(a_write_scan, i_clk, i_rst_n, we |-> (r_state == S_EMIT), "RAM write outside write-back")
    `RTT_ASSERT(a_rows_bound, i_clk, i_rst_n, r_rows <= r_take, "more report rows than requested")
endmodule

>>> tb/tb_reinforced_template_table_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_reinforced_template_table_top
// Self-checking bench for the template table. A scoreboard class keeps its own
// copy of the table and predicts every result word of each accepted request.
// It runs a directed opening, then random merges and reports under several
// capacity settings, with bursty requests and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_reinforced_template_table_top;
    import rtt_pkg::*;

    localparam int WatchdogLimit = 30000;

    class template_scoreboard;
        logic [31:0] tbl_hash      [Capacity];
        logic [15:0] tbl_reinforce [Capacity];
        logic [15:0] tbl_seen      [Capacity];
        logic [15:0] tbl_imin      [Capacity];
        logic [15:0] tbl_imax      [Capacity];
        int          fill;
        logic [6:0]  capacity_reg;
        t_rsp        pending_rows[$];
        int          errors;
        int          action_hits[8];

        function void clear_table();
            fill = 0;
            capacity_reg = 7'(Capacity);
        endfunction

        function t_rsp row_of(t_action act, logic acc, int s, logic lst);
            t_rsp r;
            r.action = act;
            r.accepted = acc;
            r.slot = 6'(s);
            r.row_hash = tbl_hash[s];
            r.row_reinforce = tbl_reinforce[s];
            r.row_last_seen = tbl_seen[s];
            r.row_interval_min = tbl_imin[s];
            r.row_interval_max = tbl_imax[s];
            r.last = lst;
            return r;
        endfunction

        function void store_record(int s, t_req q);
            tbl_hash[s] = q.key_hash;
            tbl_reinforce[s] = q.record_count;
            tbl_imin[s] = q.interval_min_ms;
            tbl_imax[s] = q.interval_max_ms;
            tbl_seen[s] = q.sweep_number;
        endfunction

        // Apply one request to the table copy and queue the rows it produces.
        function void note_request(t_req q);
            int   limit;
            int   w;
            int   take;
            int   best;
            bit   found;
            bit   changed;
            logic [63:0] taken;
            limit = (capacity_reg > Capacity) ? Capacity : int'(capacity_reg);
            if (limit == 0) limit = 1;
            if (q.operation == OP_LOCAL || q.operation == OP_WIRE) begin
                for (int i = 0; i < fill; i++) begin
                    if (tbl_hash[i] == q.key_hash) begin
                        changed = 0;
                        if (q.operation == OP_LOCAL) begin
                            if (tbl_reinforce[i] != Sat16) tbl_reinforce[i]++;
                            changed = 1;
                        end else if (q.record_count > tbl_reinforce[i]) begin
                            tbl_reinforce[i] = q.record_count;
                            changed = 1;
                        end
                        tbl_seen[i] = q.sweep_number;
                        if (q.interval_min_ms < tbl_imin[i]) begin
                            tbl_imin[i] = q.interval_min_ms;
                            changed = 1;
                        end
                        if (q.interval_max_ms > tbl_imax[i]) begin
                            tbl_imax[i] = q.interval_max_ms;
                            changed = 1;
                        end
                        pending_rows.push_back(row_of(ACT_UPDATED, changed, i, 1'b1));
                        return;
                    end
                end
                if (fill < limit) begin
                    store_record(fill, q);
                    pending_rows.push_back(row_of(ACT_APPENDED, 1'b1, fill, 1'b1));
                    fill++;
                    return;
                end
                w = 0;
                for (int i = 1; i < fill; i++) begin
                    if (tbl_reinforce[i] < tbl_reinforce[w] ||
                        (tbl_reinforce[i] == tbl_reinforce[w] && tbl_seen[i] < tbl_seen[w]))
                        w = i;
                end
                if (q.record_count < tbl_reinforce[w]) begin
                    pending_rows.push_back(row_of(ACT_REJECTED, 1'b0, w, 1'b1));
                end else begin
                    store_record(w, q);
                    pending_rows.push_back(row_of(ACT_REPLACED, 1'b1, w, 1'b1));
                end
            end else if (q.operation == OP_REPORT) begin
                take = (int'(q.report_count) < fill) ? int'(q.report_count) : fill;
                taken = '0;
                for (int k = 0; k < take; k++) begin
                    best = 0;
                    found = 0;
                    for (int i = 0; i < fill; i++) begin
                        if (taken[i]) continue;
                        if (!found || tbl_reinforce[i] > tbl_reinforce[best] ||
                            (tbl_reinforce[i] == tbl_reinforce[best] &&
                             tbl_seen[i] > tbl_seen[best])) begin
                            best = i;
                            found = 1;
                        end
                    end
                    taken[best] = 1'b1;
                    pending_rows.push_back(row_of(ACT_REPORT, 1'b0, best, k + 1 == take));
                end
            end
        endfunction

        function void compare_field(string name, longint unsigned exp, longint unsigned act);
            if (exp != act) begin
                errors++;
                $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
            end
        endfunction

        function void check_row(t_rsp got);
            t_rsp exp;
            if (pending_rows.size() == 0) begin
                errors++;
                $error("result word with no request waiting for it: %p", got);
                return;
            end
            exp = pending_rows.pop_front();
            action_hits[got.action]++;
            compare_field("action", exp.action, got.action);
            compare_field("accepted", exp.accepted, got.accepted);
            compare_field("slot", exp.slot, got.slot);
            compare_field("row_hash", exp.row_hash, got.row_hash);
            compare_field("row_reinforce", exp.row_reinforce, got.row_reinforce);
            compare_field("row_last_seen", exp.row_last_seen, got.row_last_seen);
            compare_field("row_interval_min", exp.row_interval_min, got.row_interval_min);
            compare_field("row_interval_max", exp.row_interval_max, got.row_interval_max);
            compare_field("last", exp.last, got.last);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    rtt_req_if req_if ();
    rtt_rsp_if rsp_if ();
    rtt_cfg_if cfg_if ();

    reinforced_template_table_top u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    template_scoreboard table_sb = new();

    int   quiet_cycles = 0;
    int   rows_taken = 0;
    int   requests_taken = 0;
    int   burst_left = 0;
    bit   bursty = 1'b1;
    bit   long_hold_done = 1'b0;
    int   stall_style = 0;
    logic [15:0] sweep_now = 16'd1;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        req_if.valid = 1'b0;
        req_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        rsp_if.ready = 1'b0;
    end

    // Result receiver: its stall pattern changes at random moments, and
    // once it holds off for a long stretch so the table backs up its input.
    always @(negedge i_clk) begin
        if (!long_hold_done && rows_taken >= 40) begin
            long_hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (400) @(negedge i_clk);
        end
        if ($urandom_range(0, 39) == 0) stall_style = $urandom_range(0, 2);
        case (stall_style)
            0: rsp_if.ready <= 1'b1;
            1: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            default: rsp_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (rsp_if.valid && rsp_if.ready) begin
            table_sb.check_row(rsp_if.data);
            rows_taken++;
        end
    end

    // Watchdog: counts cycles in which no channel moves a word.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchdogLimit) begin
            $display("watchdog expired with %0d words outstanding",
                     table_sb.pending_rows.size());
            $display("reinforced_template_table_top regression: fail");
            $finish;
        end
    end

    task automatic send_request(t_req q);
        if (bursty && burst_left == 0) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
            burst_left = $urandom_range(1, 8);
        end
        if (burst_left > 0) burst_left--;
        @(negedge i_clk);
        req_if.valid = 1'b1;
        req_if.data = q;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        table_sb.note_request(q);
        requests_taken++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (table_sb.pending_rows.size() != 0) @(posedge i_clk);
        // Requests with no result word never leave the idle state; this wait adds margin.
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [6:0] value);
        wait_drained();
        @(negedge i_clk);
        cfg_if.valid = 1'b1;
        cfg_if.data = value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        table_sb.capacity_reg = value;
        @(negedge i_clk);
        cfg_if.valid = 1'b0;
    endtask

    function automatic t_req make_request(t_op op, logic [31:0] h, logic [15:0] cnt,
                                          logic [15:0] lo, logic [15:0] hi,
                                          logic [15:0] sw, logic [6:0] rows);
        t_req q;
        q.operation = op;
        q.key_hash = h;
        q.record_count = cnt;
        q.interval_min_ms = lo;
        q.interval_max_ms = hi;
        q.sweep_number = sw;
        q.report_count = rows;
        return q;
    endfunction

    // Random request; keys mostly come from a small pool so that merges find
    // matches and a full table has to pick a victim.
    function automatic t_req random_request(int pool);
        t_req q;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) q.operation = OP_LOCAL;
        else if (pick < 85) q.operation = OP_WIRE;
        else if (pick < 96) q.operation = OP_REPORT;
        else q.operation = OP_NONE;
        if ($urandom_range(0, 9) < 8) q.key_hash = 32'h5A00_0000 + $urandom_range(0, pool - 1);
        else q.key_hash = $urandom;
        pick = $urandom_range(0, 3);
        if (pick < 2) q.record_count = 16'($urandom_range(0, 8));
        else if (pick == 2) q.record_count = 16'($urandom);
        else q.record_count = 16'hFFFF - 16'($urandom_range(0, 3));
        q.interval_min_ms = 16'($urandom_range(20, 2000));
        q.interval_max_ms = q.interval_min_ms + 16'($urandom_range(0, 3000));
        if ($urandom_range(0, 7) == 0) begin
            q.interval_min_ms = 16'($urandom);
            q.interval_max_ms = 16'($urandom);
        end
        if ($urandom_range(0, 2) == 0) sweep_now = sweep_now + 16'($urandom_range(1, 3));
        q.sweep_number = ($urandom_range(0, 15) == 0) ? 16'($urandom) : sweep_now;
        q.report_count = 7'($urandom_range(0, 6));
        return q;
    endfunction

    task automatic random_phase(int count, int pool);
        repeat (count) begin
            if ($urandom_range(0, 29) == 0) bursty = !bursty;
            send_request(random_request(pool));
        end
    endtask

    initial begin
        table_sb.clear_table();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed opening: empty-table report, ignored opcode, field extremes,
        // saturation, wire merges with and without a durable change.
        send_request(make_request(OP_REPORT, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 7'd5));
        send_request(make_request(OP_NONE, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                  16'hFFFF, 7'h7F));
        send_request(make_request(OP_LOCAL, 32'h0, 16'h0, 16'h0, 16'hFFFF, 16'h0, 7'd0));
        send_request(make_request(OP_LOCAL, 32'hFFFF_FFFF, 16'hFFFE, 16'd100, 16'd200,
                                  16'hFFFF, 7'd0));
        send_request(make_request(OP_LOCAL, 32'hFFFF_FFFF, 16'd3, 16'd150, 16'd150,
                                  16'd7, 7'd0));
        send_request(make_request(OP_LOCAL, 32'hFFFF_FFFF, 16'd3, 16'd150, 16'd150,
                                  16'd8, 7'd0));
        send_request(make_request(OP_WIRE, 32'hFFFF_FFFF, 16'd5, 16'd120, 16'd180,
                                  16'd9, 7'd0));
        send_request(make_request(OP_WIRE, 32'h1234_5678, 16'd10, 16'd900, 16'd300,
                                  16'd9, 7'd0));
        send_request(make_request(OP_WIRE, 32'h1234_5678, 16'd4, 16'd500, 16'd300,
                                  16'd10, 7'd0));
        send_request(make_request(OP_WIRE, 32'h1234_5678, 16'd4, 16'd400, 16'd1000,
                                  16'd11, 7'd0));
        send_request(make_request(OP_WIRE, 32'h1234_5678, 16'd40, 16'd900, 16'd300,
                                  16'd12, 7'd0));
        send_request(make_request(OP_WIRE, 32'hAAAA_5555, 16'h5555, 16'hAAAA, 16'h5555,
                                  16'hAAAA, 7'd0));
        send_request(make_request(OP_REPORT, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 7'd0));
        send_request(make_request(OP_REPORT, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 7'h7F));
        send_request(make_request(OP_REPORT, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 7'd2));

        // Capacity lowered below the fill: new keys reject or replace the weakest.
        write_capacity(7'd1);
        send_request(make_request(OP_LOCAL, 32'h0BAD_0001, 16'd0, 16'd1, 16'd2,
                                  16'd20, 7'd0));
        send_request(make_request(OP_WIRE, 32'h0BAD_0002, 16'd9, 16'd1, 16'd2,
                                  16'd21, 7'd0));
        write_capacity(7'd0);
        send_request(make_request(OP_WIRE, 32'h0BAD_0003, 16'd9, 16'd5, 16'd6,
                                  16'd22, 7'd0));
        send_request(make_request(OP_REPORT, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 7'd64));

        // Capacity above the table size acts as a full table; the pool of keys
        // is larger than the table, though this phase is too short to fill it.
        write_capacity(7'h7F);
        random_phase(45, 80);
        // The sender pauses here until every result word has come back.
        write_capacity(7'd3);
        random_phase(25, 6);
        write_capacity(7'd64);
        random_phase(20, 70);
        send_request(make_request(OP_REPORT, 32'h0, 16'h0, 16'h0, 16'h0, 16'h0, 7'd64));

        wait_drained();
        $display("%0d requests and %0d result words checked over capacities 1, 0, 127, 3, 64",
                 requests_taken, rows_taken);
        $display("updated %0d, appended %0d, replaced %0d, rejected %0d, report rows %0d",
                 table_sb.action_hits[ACT_UPDATED], table_sb.action_hits[ACT_APPENDED],
                 table_sb.action_hits[ACT_REPLACED], table_sb.action_hits[ACT_REJECTED],
                 table_sb.action_hits[ACT_REPORT]);
        if (table_sb.errors == 0 && table_sb.pending_rows.size() == 0) begin
            $display("reinforced_template_table_top regression: pass");
        end else begin
            $display("reinforced_template_table_top regression: fail");
        end
        $finish;
    end
endmodule
